/* design/cfa_pkg.sv */
`default_nettype none

package cfa_pkg;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_NEXT  = 2'd2,
    FIT_WORST = 2'd3
  } fit_mode_e;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // candidates already held by the scan
  typedef struct packed {
    logic found;
    logic lo_found;
  } cfa_seen_t;

  // what the scan keeps from the hole just closed
  typedef struct packed {
    logic take_main;
    logic take_lo;
  } cfa_take_t;

endpackage

`default_nettype wire

/* design/cfa_hole_eval.sv */
`default_nettype none

module cfa_hole_eval import cfa_pkg::*; #(
  parameter int MAP_CELLS = 128
) (
  input  fit_mode_e                        mode_i,
  input  logic                             hole_vld_i,
  input  logic [$clog2(MAP_CELLS)-1:0]     hole_start_i,
  input  logic [$clog2(MAP_CELLS+1)-1:0]   hole_len_i,
  input  logic [$clog2(MAP_CELLS+1)-1:0]   size_i,
  input  logic [$clog2(MAP_CELLS)-1:0]     base_i,
  input  logic [$clog2(MAP_CELLS+1)-1:0]   best_len_i,
  input  cfa_seen_t                        seen_i,
  output cfa_take_t                        take_o,
  output logic [$clog2(MAP_CELLS)-1:0]     main_start_o
);

  localparam int AW = $clog2(MAP_CELLS);
  localparam int CW = $clog2(MAP_CELLS + 1);

  logic [CW-1:0] start_w;
  logic [CW-1:0] base_w;
  logic [CW-1:0] end_w;
  logic [CW-1:0] up_len;
  logic [AW-1:0] up_start;
  logic          fits;

  assign start_w  = CW'(hole_start_i);
  assign base_w   = CW'(base_i);
  assign end_w    = start_w + hole_len_i;
  assign up_start = (start_w >= base_w) ? hole_start_i : base_i;
  assign up_len   = end_w - CW'(up_start);
  assign fits     = hole_len_i >= size_i;

  always_comb begin
    take_o       = '0;
    main_start_o = hole_start_i;
    unique case (mode_i)
      FIT_FIRST: begin
        take_o.take_main = hole_vld_i && fits && !seen_i.found;
      end
      FIT_BEST: begin
        take_o.take_main = hole_vld_i && fits &&
                           (!seen_i.found || hole_len_i < best_len_i);
      end
      FIT_WORST: begin
        take_o.take_main = hole_vld_i && fits &&
                           (!seen_i.found || hole_len_i > best_len_i);
      end
      FIT_NEXT: begin
        // part of the hole at or above the roving pointer
        main_start_o     = up_start;
        take_o.take_main = hole_vld_i && (end_w > base_w) && (up_len >= size_i) &&
                           !seen_i.found;
        // wrapped candidate below the pointer
        take_o.take_lo   = hole_vld_i && (start_w < base_w) && fits &&
                           !seen_i.lo_found;
      end
      default: begin
        take_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/contiguous_fit_allocator.sv */
`default_nettype none
// Contiguous fit allocator.
// Command channel: an item (kind_i, owner_id_i, request_size_i) is taken at a
// clock edge with start_i high and busy_o low. busy_o stays high while the
// item is worked on. Each item gives one result on granted_o/start_index_o,
// shown for one cycle with result_valid_o; the receiver cannot stall it.
// fit_mode_i is written when fit_mode_we_i is high; the user must write it
// only while idle, as the block itself does not enforce it.
// Allocate: the cell map memory is read once from cell 0 to MAP_CELLS-1, one
// cell a cycle, holes are rated as they close, then the chosen run is
// written one cell a cycle. A size of zero or above MAP_CELLS is refused in
// the cycle after the item is taken, without a scan.
// Clear: a write sweep over the map that frees every cell, then the result.
// Reset: the same sweep runs after reset with busy_o high and gives no
// result; the roving pointer and fit_mode reset to zero.
module contiguous_fit_allocator import cfa_pkg::*; #(
  parameter int MAP_CELLS = 128,
  parameter int OWNER_IDS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             kind_i,
  input  logic [$clog2(OWNER_IDS)-1:0]     owner_id_i,
  input  logic [$clog2(MAP_CELLS+1)-1:0]   request_size_i,
  input  logic                             fit_mode_we_i,
  input  logic [1:0]                       fit_mode_i,
  output logic                             result_valid_o,
  output logic                             granted_o,
  output logic [$clog2(MAP_CELLS)-1:0]     start_index_o
);

  localparam int AW = $clog2(MAP_CELLS);
  localparam int CW = $clog2(MAP_CELLS + 1);
  localparam int OW = $clog2(OWNER_IDS);
  localparam int MW = OW + 1;

  localparam logic [AW-1:0] LAST_CELL = AW'(MAP_CELLS - 1);
  localparam logic [CW-1:0] NUM_CELLS = CW'(MAP_CELLS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLR   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_PICK  = 3'd3;
  localparam logic [2:0] ST_ALLOC = 3'd4;

  // memory word: {used, owner}
  logic [MW-1:0] mem_q [MAP_CELLS];
  logic [MW-1:0] mem_rdata_q;
  logic          mem_we;
  logic [MW-1:0] mem_wdata;

  logic [2:0]    state_q, state_d;
  fit_mode_e     mode_q, mode_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          issue_q, issue_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] run_len_q, run_len_d;
  logic [AW-1:0] run_start_q, run_start_d;
  cfa_seen_t     seen_q, seen_d;
  logic [AW-1:0] pick_q, pick_d;
  logic [CW-1:0] best_q, best_d;
  logic [AW-1:0] lo_pick_q, lo_pick_d;
  logic [AW-1:0] rover_q, rover_d;
  logic [CW-1:0] size_q, size_d;
  logic [CW-1:0] remain_q, remain_d;
  logic [OW-1:0] owner_q, owner_d;
  logic          clr_res_q, clr_res_d;
  logic          res_vld_q, res_vld_d;
  logic          granted_q, granted_d;
  logic [AW-1:0] res_start_q, res_start_d;

  logic          accept;
  logic          cell_used;
  logic          hole_vld;
  logic [AW-1:0] hole_start;
  logic [CW-1:0] hole_len;
  cfa_take_t     take;
  logic [AW-1:0] main_start;
  logic          sel_found;
  logic [AW-1:0] sel_pick;
  logic [CW-1:0] sel_end;

  assign busy_o         = state_q != ST_IDLE;
  assign accept         = start_i && !busy_o;
  assign result_valid_o = res_vld_q;
  assign granted_o      = granted_q;
  assign start_index_o  = res_start_q;
  assign cell_used      = mem_rdata_q[MW-1];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[addr_q];
  end

  // hole closes on a used cell after free ones, or at the end of the map
  always_comb begin
    hole_vld    = 1'b0;
    hole_start  = run_start_q;
    hole_len    = run_len_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    if (state_q == ST_SCAN && rd_vld_q) begin
      if (cell_used) begin
        hole_vld  = run_len_q != '0;
        run_len_d = '0;
      end else begin
        if (run_len_q == '0) begin
          run_start_d = rd_idx_q;
        end
        run_len_d = run_len_q + 1'b1;
        if (rd_idx_q == LAST_CELL) begin
          hole_vld   = 1'b1;
          hole_start = (run_len_q == '0) ? rd_idx_q : run_start_q;
          hole_len   = run_len_q + 1'b1;
        end
      end
    end
  end

  cfa_hole_eval #(
    .MAP_CELLS (MAP_CELLS)
  ) u_hole_eval (
    .mode_i       (mode_q),
    .hole_vld_i   (hole_vld),
    .hole_start_i (hole_start),
    .hole_len_i   (hole_len),
    .size_i       (size_q),
    .base_i       (rover_q),
    .best_len_i   (best_q),
    .seen_i       (seen_q),
    .take_o       (take),
    .main_start_o (main_start)
  );

  assign sel_found = seen_q.found || (mode_q == FIT_NEXT && seen_q.lo_found);
  assign sel_pick  = seen_q.found ? pick_q : lo_pick_q;
  assign sel_end   = CW'(sel_pick) + size_q;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    addr_d      = addr_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    seen_d      = seen_q;
    pick_d      = pick_q;
    best_d      = best_q;
    lo_pick_d   = lo_pick_q;
    rover_d     = rover_q;
    size_d      = size_q;
    remain_d    = remain_q;
    owner_d     = owner_q;
    clr_res_d   = clr_res_q;
    res_vld_d   = 1'b0;
    granted_d   = granted_q;
    res_start_d = res_start_q;
    mem_we      = 1'b0;
    mem_wdata   = {1'b1, owner_q};

    if (fit_mode_we_i) begin
      mode_d = fit_mode_e'(fit_mode_i);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          owner_d = owner_id_i;
          size_d  = request_size_i;
          addr_d  = '0;
          if (kind_i == KIND_CLEAR) begin
            rover_d   = '0;
            clr_res_d = 1'b1;
            state_d   = ST_CLR;
          end else if (request_size_i == '0 || request_size_i > NUM_CELLS) begin
            res_vld_d   = 1'b1;
            granted_d   = 1'b0;
            res_start_d = '0;
          end else begin
            issue_d = 1'b1;
            seen_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        addr_d    = addr_q + 1'b1;
        if (addr_q == LAST_CELL) begin
          state_d     = ST_IDLE;
          res_vld_d   = clr_res_q;
          granted_d   = 1'b1;
          res_start_d = '0;
        end
      end
      ST_SCAN: begin
        if (issue_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q;
          addr_d   = addr_q + 1'b1;
          if (addr_q == LAST_CELL) begin
            issue_d = 1'b0;
          end
        end
        if (take.take_main) begin
          seen_d.found = 1'b1;
          pick_d       = main_start;
          best_d       = hole_len;
        end
        if (take.take_lo) begin
          seen_d.lo_found = 1'b1;
          lo_pick_d       = hole_start;
        end
        if (rd_vld_q && rd_idx_q == LAST_CELL) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (sel_found) begin
          addr_d   = sel_pick;
          pick_d   = sel_pick;
          remain_d = size_q;
          state_d  = ST_ALLOC;
          if (mode_q == FIT_NEXT) begin
            rover_d = (sel_end == NUM_CELLS) ? '0 : sel_end[AW-1:0];
          end
        end else begin
          res_vld_d   = 1'b1;
          granted_d   = 1'b0;
          res_start_d = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        mem_we   = 1'b1;
        addr_d   = addr_q + 1'b1;
        remain_d = remain_q - 1'b1;
        if (remain_q == CW'(1)) begin
          res_vld_d   = 1'b1;
          granted_d   = 1'b1;
          res_start_d = pick_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      mode_q      <= FIT_FIRST;
      addr_q      <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      run_len_q   <= '0;
      run_start_q <= '0;
      seen_q      <= '0;
      pick_q      <= '0;
      best_q      <= '0;
      lo_pick_q   <= '0;
      rover_q     <= '0;
      size_q      <= '0;
      remain_q    <= '0;
      owner_q     <= '0;
      clr_res_q   <= 1'b0;
      res_vld_q   <= 1'b0;
      granted_q   <= 1'b0;
      res_start_q <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      addr_q      <= addr_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      run_len_q   <= (state_q == ST_IDLE) ? '0 : run_len_d;
      run_start_q <= run_start_d;
      seen_q      <= seen_d;
      pick_q      <= pick_d;
      best_q      <= best_d;
      lo_pick_q   <= lo_pick_d;
      rover_q     <= rover_d;
      size_q      <= size_d;
      remain_q    <= remain_d;
      owner_q     <= owner_d;
      clr_res_q   <= clr_res_d;
      res_vld_q   <= res_vld_d;
      granted_q   <= granted_d;
      res_start_q <= res_start_d;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import cfa_pkg::*;

  localparam int MAP_CELLS      = 128;
  localparam int OWNER_IDS      = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic       granted;
    logic [6:0] start;
  } alloc_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic       kind_i;
  logic [3:0] owner_id_i;
  logic [7:0] request_size_i;
  logic       fit_mode_we_i;
  logic [1:0] fit_mode_i;
  logic       result_valid_o;
  logic       granted_o;
  logic [6:0] start_index_o;

  // predictor state
  logic [MAP_CELLS-1:0] map_used;
  logic [6:0]           rover;
  fit_mode_e            cur_mode;

  alloc_res_t pending_results[$];

  int items_sent;
  int clears_sent;
  int results_seen;
  int grants_seen;
  int errors;
  int idle_cycles;

  always #5 clk_i = ~clk_i;

  contiguous_fit_allocator #(
    .MAP_CELLS(MAP_CELLS),
    .OWNER_IDS(OWNER_IDS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .owner_id_i    (owner_id_i),
    .request_size_i(request_size_i),
    .fit_mode_we_i (fit_mode_we_i),
    .fit_mode_i    (fit_mode_i),
    .result_valid_o(result_valid_o),
    .granted_o     (granted_o),
    .start_index_o (start_index_o)
  );

  task automatic report(input string what, input int exp_val, input int got_val);
    $display("tb: mismatch on %s: expected %0d, got %0d at %0t", what, exp_val, got_val,
             $realtime);
    errors++;
  endtask

  function automatic alloc_res_t place_item(input logic kind, input logic [7:0] size);
    int         run [0:MAP_CELLS];
    int         sz;
    int         pick;
    int         best_len;
    int         idx;
    bit         found;
    alloc_res_t res;
    res      = '0;
    sz       = size;
    found    = 1'b0;
    pick     = 0;
    best_len = 0;
    if (kind == KIND_CLEAR) begin
      map_used    = '0;
      rover       = '0;
      res.granted = 1'b1;
      return res;
    end
    if (sz == 0 || sz > MAP_CELLS) return res;
    run[MAP_CELLS] = 0;
    for (int i = MAP_CELLS - 1; i >= 0; i--) begin
      run[i] = map_used[i] ? 0 : run[i+1] + 1;
    end
    case (cur_mode)
      FIT_FIRST: begin
        for (int i = 0; i < MAP_CELLS; i++) begin
          if (!found && run[i] >= sz) begin
            found = 1'b1;
            pick  = i;
          end
        end
      end
      FIT_NEXT: begin
        for (int k = 0; k < MAP_CELLS; k++) begin
          idx = (int'(rover) + k) % MAP_CELLS;
          if (!found && run[idx] >= sz) begin
            found = 1'b1;
            pick  = idx;
          end
        end
      end
      default: begin
        // whole holes only, rated from their first cell
        for (int i = 0; i < MAP_CELLS; i++) begin
          if (run[i] != 0 && (i == 0 || map_used[i-1]) && run[i] >= sz) begin
            if (!found || (cur_mode == FIT_BEST && run[i] < best_len) ||
                (cur_mode == FIT_WORST && run[i] > best_len)) begin
              found    = 1'b1;
              pick     = i;
              best_len = run[i];
            end
          end
        end
      end
    endcase
    if (!found) return res;
    for (int i = 0; i < sz; i++) map_used[pick+i] = 1'b1;
    if (cur_mode == FIT_NEXT) rover = 7'((pick + sz) % MAP_CELLS);
    res.granted = 1'b1;
    res.start   = 7'(pick);
    return res;
  endfunction

  task automatic send_item(input logic kind, input logic [3:0] owner, input logic [7:0] size);
    @(negedge clk_i);
    kind_i         <= kind;
    owner_id_i     <= owner;
    request_size_i <= size;
    start_i        <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(place_item(kind, size));
    items_sent++;
    if (kind == KIND_CLEAR) clears_sent++;
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0 || busy_o !== 1'b0) @(negedge clk_i);
  endtask

  task automatic set_fit_mode(input fit_mode_e mode);
    @(negedge clk_i);
    fit_mode_we_i <= 1'b1;
    fit_mode_i    <= mode;
    @(negedge clk_i);
    fit_mode_we_i <= 1'b0;
    cur_mode = mode;
  endtask

  // zero, oversize, full map and refusal on a full map
  task automatic test_size_limits();
    send_item(KIND_ALLOC, 4'd0, 8'd0);
    send_item(KIND_ALLOC, 4'd15, 8'd255);
    send_item(KIND_ALLOC, 4'd5, 8'd129);
    send_item(KIND_ALLOC, 4'd10, 8'd128);
    send_item(KIND_ALLOC, 4'd3, 8'd1);
    send_item(KIND_CLEAR, 4'd15, 8'd255);
  endtask

  // each rule: fill to an exact end, with a refusal in between
  task automatic test_fit_modes();
    fit_mode_e modes [4];
    modes = '{FIT_FIRST, FIT_BEST, FIT_NEXT, FIT_WORST};
    foreach (modes[m]) begin
      wait_idle();
      set_fit_mode(modes[m]);
      send_item(KIND_CLEAR, 4'(m), 8'd0);
      send_item(KIND_ALLOC, 4'(m + 1), 8'd3);
      send_item(KIND_ALLOC, 4'(m + 7), 8'd120);
      send_item(KIND_ALLOC, 4'(m + 2), 8'd6);
      send_item(KIND_ALLOC, 4'(m + 12), 8'd5);
    end
  endtask

  task automatic test_random_phase(input fit_mode_e mode, input int n, input int idle_pct);
    int         r;
    logic       kind;
    logic [3:0] owner;
    logic [7:0] size;
    wait_idle();
    set_fit_mode(mode);
    repeat (n) begin
      if ($urandom_range(99) < idle_pct)
        hold_off($urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(5, 2*MAP_CELLS + 40));
      if ($urandom_range(49) == 0) wait_idle();
      r     = $urandom_range(99);
      kind  = KIND_ALLOC;
      owner = 4'($urandom_range(OWNER_IDS - 1));
      if (r < 6) begin
        kind = KIND_CLEAR;
        size = 8'($urandom_range(255));
      end else if (r < 10) begin
        size = 8'd0;
      end else if (r < 14) begin
        size = 8'($urandom_range(255, MAP_CELLS + 1));
      end else if (r < 30) begin
        size = 8'($urandom_range(MAP_CELLS, 17));
      end else begin
        size = 8'($urandom_range(16, 1));
      end
      send_item(kind, owner, size);
    end
  endtask

  always @(posedge clk_i) begin
    alloc_res_t exp_res;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result", 0, 1);
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res.granted) grants_seen++;
        if (granted_o !== exp_res.granted) report("granted", exp_res.granted, granted_o);
        if (start_index_o !== exp_res.start) report("start_index", exp_res.start, start_index_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || result_valid_o === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired after %0d quiet cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int        idle_plan [3];
    fit_mode_e modes     [4];
    idle_plan      = '{9, 84, 0};
    modes          = '{FIT_FIRST, FIT_BEST, FIT_NEXT, FIT_WORST};
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    kind_i         = KIND_ALLOC;
    owner_id_i     = '0;
    request_size_i = '0;
    fit_mode_we_i  = 1'b0;
    fit_mode_i     = FIT_FIRST;
    map_used       = '0;
    rover          = '0;
    cur_mode       = FIT_FIRST;
    items_sent     = 0;
    clears_sent    = 0;
    results_seen   = 0;
    grants_seen    = 0;
    errors         = 0;
    idle_cycles    = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait_idle();
    set_fit_mode(FIT_FIRST);
    test_size_limits();
    test_fit_modes();
    foreach (idle_plan[p]) begin
      foreach (modes[m]) test_random_phase(modes[m], 75, idle_plan[p]);
    end

    wait_idle();
    repeat (2*MAP_CELLS + 8) @(posedge clk_i);
    if (pending_results.size() != 0) report("results outstanding", 0, pending_results.size());

    $display("tb: %0d items sent (%0d clears), %0d results checked, %0d granted",
             items_sent, clears_sent, results_seen, grants_seen);
    $display("tb: all four fit rules under three sender idle rates, %0d mismatches", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
design/cfa_pkg.sv
design/cfa_hole_eval.sv
design/contiguous_fit_allocator.sv
tb/sv/testbench.sv
